// File: rtl/core/rbe_pkg.sv
// ----------------------------------------------------------------------------
// Rolling band envelope package
// Shared widths, register indexes and controller/datapath command types.
// ----------------------------------------------------------------------------
package rbe_pkg;

  localparam int unsigned PriceW  = 24;
  localparam int unsigned LenW    = 9;
  localparam int unsigned KW      = 12;
  localparam int unsigned BandW   = 32;
  localparam int unsigned RootW   = 32;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 16;

  localparam logic [CfgIdxW-1:0] RegWindowLength = 8'd0;
  localparam logic [CfgIdxW-1:0] RegBandFactor   = 8'd1;

  localparam logic [LenW-1:0] LenReset = 9'd20;
  localparam logic [KW-1:0]   KReset   = 12'd512;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take the input beat, read the old slot
    logic update;     // update sums and write the window
    logic sq_start;   // start D computation and square root
    logic sq_step;    // one square-root iteration
    logic spread;     // form numerators
    logic div_start;  // load dividers
    logic div_step;   // one divider iteration
    logic finish;     // register result
    logic clear;      // empty the window
  } rbe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;       // window holds N prices after this item
    logic sq_done;
    logic div_done;
  } rbe_sts_t;

endpackage

// File: rtl/core/rbe_datapath.sv
// ----------------------------------------------------------------------------
// Rolling band envelope datapath
// Window memory, running sums, serial square root and two serial dividers.
// ----------------------------------------------------------------------------
module rbe_datapath #(
  parameter int unsigned WindowMax = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rbe_pkg::rbe_cmd_t                cmd_i,
  output rbe_pkg::rbe_sts_t                sts_o,
  input  logic [rbe_pkg::PriceW-1:0]       price_i,
  input  logic                             restart_i,
  input  logic [rbe_pkg::LenW-1:0]         len_i,
  input  logic [rbe_pkg::KW-1:0]           k_i,
  output logic                             valid_o,
  output logic [rbe_pkg::BandW-1:0]        upper_o,
  output logic [rbe_pkg::BandW-1:0]        lower_o
);
  import rbe_pkg::*;

  localparam int unsigned AW    = (WindowMax > 1) ? $clog2(WindowMax) : 1;
  localparam int unsigned NW    = $clog2(WindowMax + 1);
  localparam int unsigned SumW  = PriceW + NW;
  localparam int unsigned QW    = 2 * PriceW + NW;
  localparam int unsigned DW    = 64;
  localparam int unsigned NumW  = 64;
  localparam int unsigned DenW  = NW + 8;
  localparam int unsigned CntW  = 7;

  // Effective window length, clamped to 1..WindowMax.
  logic [NW-1:0] n_eff;
  always_comb begin
    if (len_i == '0) begin
      n_eff = NW'(1);
    end else if (32'(len_i) > WindowMax) begin
      n_eff = NW'(WindowMax);
    end else begin
      n_eff = NW'(len_i);
    end
  end

  // Window memory with registered read.
  logic [PriceW-1:0] mem_q [WindowMax];
  logic [PriceW-1:0] old_q;
  logic [AW-1:0]     slot_q, slot_d;
  logic [NW-1:0]     fill_q, fill_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [QW-1:0]     sqs_q, sqs_d;
  logic [PriceW-1:0] price_q;
  logic              evict_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      old_q <= mem_q[slot_d];
    end
    if (cmd_i.update) begin
      mem_q[slot_q] <= price_q;
    end
  end

  // Slot seen by the load, after an optional restart.
  always_comb begin
    slot_d = (restart_i) ? '0 : slot_q;
    fill_d = (restart_i) ? '0 : fill_q;
    sum_d  = (restart_i) ? '0 : sum_q;
    sqs_d  = (restart_i) ? '0 : sqs_q;
  end

  // Running state update.
  logic [2*PriceW-1:0] old_sq, new_sq;
  logic [AW:0]         slot_nx;
  assign old_sq  = old_q * old_q;
  assign new_sq  = price_q * price_q;
  assign slot_nx = {1'b0, slot_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      sqs_q   <= '0;
      evict_q <= 1'b0;
      price_q <= '0;
    end else if (cmd_i.clear) begin
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
      sqs_q  <= '0;
    end else if (cmd_i.load) begin
      price_q <= price_i;
      slot_q  <= slot_d;
      sum_q   <= sum_d;
      sqs_q   <= sqs_d;
      evict_q <= (fill_d >= n_eff);
      fill_q  <= (fill_d >= n_eff) ? fill_d : fill_d + 1'b1;
    end else if (cmd_i.update) begin
      if (evict_q) begin
        sum_q <= sum_q - SumW'(old_q) + SumW'(price_q);
        sqs_q <= sqs_q - QW'(old_sq) + QW'(new_sq);
      end else begin
        sum_q <= sum_q + SumW'(price_q);
        sqs_q <= sqs_q + QW'(new_sq);
      end
      slot_q <= (NW'(slot_nx) >= n_eff) ? '0 : slot_q + 1'b1;
    end
  end

  assign sts_o.full = (fill_q >= n_eff);

  // D = N*Q - S*S, then a bit-pair square root, one step per cycle.
  logic [DW-1:0]    rem_q, res_q, bit_q;
  logic [DW-1:0]    trial;
  logic [RootW-1:0] root;
  assign trial = res_q + bit_q;
  assign root  = RootW'(res_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      res_q <= '0;
      bit_q <= '0;
    end else if (cmd_i.sq_start) begin
      rem_q <= DW'(n_eff) * DW'(sqs_q) - DW'(sum_q) * DW'(sum_q);
      res_q <= '0;
      bit_q <= DW'(1) << 62;
    end else if (cmd_i.sq_step && bit_q != '0) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end
  assign sts_o.sq_done = (bit_q == '0);

  // Numerators 256*S +/- k*r, kept as sign and magnitude.
  logic [NumW-1:0] base_q, spr_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.spread) begin
      base_q <= NumW'(sum_q) << 8;
      spr_q  <= NumW'(k_i) * NumW'(root);
    end
  end

  // Two restoring dividers by 256*N, one quotient bit per cycle.
  logic [DenW-1:0] den;
  logic [NumW-1:0] uq_q, lq_q;
  logic [DenW:0]   ur_q, lr_q;
  logic            lneg_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW:0]   ur_sh, lr_sh;
  assign den   = {n_eff, 8'd0};
  assign ur_sh = {ur_q[DenW-1:0], uq_q[NumW-1]};
  assign lr_sh = {lr_q[DenW-1:0], lq_q[NumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      lneg_q <= 1'b0;
      uq_q   <= '0;
      lq_q   <= '0;
      ur_q   <= '0;
      lr_q   <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q  <= CntW'(NumW);
      uq_q   <= base_q + spr_q;
      lneg_q <= (spr_q > base_q);
      lq_q   <= (spr_q > base_q) ? spr_q - base_q : base_q - spr_q;
      ur_q   <= '0;
      lr_q   <= '0;
    end else if (cmd_i.div_step && cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
      if (ur_sh >= {1'b0, den}) begin
        ur_q <= ur_sh - {1'b0, den};
        uq_q <= {uq_q[NumW-2:0], 1'b1};
      end else begin
        ur_q <= ur_sh;
        uq_q <= {uq_q[NumW-2:0], 1'b0};
      end
      if (lr_sh >= {1'b0, den}) begin
        lr_q <= lr_sh - {1'b0, den};
        lq_q <= {lq_q[NumW-2:0], 1'b1};
      end else begin
        lr_q <= lr_sh;
        lq_q <= {lq_q[NumW-2:0], 1'b0};
      end
    end
  end
  assign sts_o.div_done = (cnt_q == '0);

  // Floor of a negative quotient: -(q + (rem != 0)).
  logic [BandW-1:0] lo_val;
  always_comb begin
    if (lneg_q) begin
      lo_val = BandW'(~lq_q + 1'b1) - ((lr_q != '0) ? BandW'(1) : BandW'(0));
    end else begin
      lo_val = BandW'(lq_q);
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
      upper_o <= '0;
      lower_o <= '0;
    end else if (cmd_i.finish) begin
      valid_o <= sts_o.full;
      upper_o <= sts_o.full ? BandW'(uq_q) : '0;
      lower_o <= sts_o.full ? lo_val : '0;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= NW'(WindowMax))
    else $error("fill count beyond window");
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_q) < WindowMax)
    else $error("slot out of range");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (fill_q == '0 && sum_q == '0))
    else $error("clear did not empty window");
`endif

endmodule

// File: rtl/core/rbe_ctrl.sv
// ----------------------------------------------------------------------------
// Rolling band envelope controller
// Sequences one item through update, square root and division.
// ----------------------------------------------------------------------------
module rbe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              cfg_len_wr_i,
  output rbe_pkg::rbe_cmd_t cmd_o,
  input  rbe_pkg::rbe_sts_t sts_i
);
  import rbe_pkg::*;

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StUpd   = 8'b00000010,
    StSqSt  = 8'b00000100,
    StSqrt  = 8'b00001000,
    StSpr   = 8'b00010000,
    StDivLd = 8'b00100000,
    StDiv   = 8'b01000000,
    StOut   = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    ov_d    = ov_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.clear = cfg_len_wr_i;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StUpd;
        end
      end
      StUpd: begin
        cmd_o.update = 1'b1;
        state_d      = StSqSt;
      end
      StSqSt: begin
        cmd_o.sq_start = 1'b1;
        state_d        = StSqrt;
      end
      StSqrt: begin
        cmd_o.sq_step = 1'b1;
        if (sts_i.sq_done) begin
          state_d = StSpr;
        end
      end
      StSpr: begin
        cmd_o.spread    = 1'b1;
        state_d         = StDivLd;
      end
      StDivLd: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDiv;
      end
      StDiv: begin
        cmd_o.div_step  = 1'b1;
        if (sts_i.div_done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          ov_d         = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      ov_q     <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == StIdle)
    else $error("ready outside idle");
  a_finish_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == StIdle && ov_q)
    else $error("finish did not raise output");
  a_div_after_spr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSpr |=> state_q == StDivLd)
    else $error("divider load out of order");
`endif

endmodule

// File: rtl/core/rolling_band_envelope_top.sv
// ----------------------------------------------------------------------------
// Rolling band envelope top level
// Rolling mean +/- k standard deviation bands over the last N prices.
//
//   Channel   Dir  Payload
//   s_axis    in   tdata[23:0] price, tuser restart
//   m_axis    out  tdata[0] bands_valid, [32:1] upper, [64:33] lower
//   cfg       in   cfg_idx_i register index, cfg_data_i value
//
// Throughput is set by the bit-pair square root (one step per cycle) and the
// bit-serial dividers (one quotient bit per cycle); the next beat is accepted
// only once the current item's result has been registered.
// The window memory needs no clearing pass; reset clears counts and sums.
// A stalled result stays in the output register; the next item may be
// taken and processed meanwhile, waiting only to deliver its own result.
// ----------------------------------------------------------------------------
module rolling_band_envelope_top #(
  parameter int unsigned WindowMax = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // price
  input  logic        s_axis_tuser,  // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // bands_valid, upper_band, lower_band, pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import rbe_pkg::*;

  rbe_cmd_t cmd;
  rbe_sts_t sts;
  logic [LenW-1:0]  len_q;
  logic [KW-1:0]    k_q;
  logic             cfg_fire, len_wr;
  logic             valid_r;
  logic [BandW-1:0] up_r, lo_r;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign len_wr      = cfg_fire && (cfg_idx_i == RegWindowLength);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenReset;
      k_q   <= KReset;
    end else if (cfg_fire) begin
      if (cfg_idx_i == RegWindowLength) begin
        len_q <= cfg_data_i[LenW-1:0];
      end else if (cfg_idx_i == RegBandFactor) begin
        k_q <= cfg_data_i[KW-1:0];
      end
    end
  end

  rbe_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .cfg_len_wr_i (len_wr),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  rbe_datapath #(.WindowMax(WindowMax)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .price_i   (s_axis_tdata),
    .restart_i (s_axis_tuser),
    .len_i     (len_q),
    .k_i       (k_q),
    .valid_o   (valid_r),
    .upper_o   (up_r),
    .lower_o   (lo_r)
  );

  assign m_axis_tdata = {7'd0, lo_r, up_r, valid_r};

endmodule
